/* hw/rtl/lht_pkg.sv */
// Shared constants, codes and control structs for the linear hash table.
// No dependencies.
package lht_pkg;

    localparam int MAX_BUCKETS_DEF      = 64;
    localparam int SLOTS_PER_BUCKET_DEF = 16;
    localparam int START_BUCKETS_DEF    = 2;
    localparam int KEY_BITS_DEF         = 31;

    localparam int HOME_W = 6;
    localparam int STAT_W = 2;
    localparam int ODATA_W = 16;   // found, status, home_bucket padded to bytes

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_LIMIT = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load_req;
        logic hash_start;
        logic hash_sel1;     // divisor at level + 1
        logic hash_src_mem;  // operand from key store read data
        logic set_home;
        logic fill_rd;
        logic fill_sel_old;  // fill port at split pointer instead of home
        logic fill_cap;
        logic key_rd_scan;
        logic scan_next;
        logic set_found;
        logic ins_write;
        logic key_rd_split;
        logic split_write;
        logic fill_wr_old;
        logic fill_wr_new;
        logic split_finish;
        logic out_load;
    } lht_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hash_done;
        logic below_sp;
        logic is_search;
        logic can_split;
        logic idx_end;
        logic match;
        logic out_busy;
    } lht_stat_t;

endpackage

/* hw/rtl/lht_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/lht_mod.sv */
// Multi-cycle remainder unit: operand mod divisor, eight operand bits per cycle.
// Uses lht_pkg defaults only through the parent.
module lht_mod #(
    parameter int KW = 31,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [KW-1:0] operand,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] result
);

    localparam int NSTEP = (KW + 7) / 8;
    localparam int PW    = NSTEP * 8;
    localparam int CW    = $clog2(NSTEP + 1);

    logic [PW-1:0] sh_reg;
    logic [DW-1:0] d_reg;
    logic [DW-1:0] r_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    // restoring remainder over one byte, msb first
    function automatic logic [DW-1:0] rem_byte(input logic [DW-1:0] r,
                                               input logic [7:0] b,
                                               input logic [DW-1:0] d);
        logic [DW:0]   t;
        logic [DW-1:0] acc;
        acc = r;
        for (int i = 7; i >= 0; i--)
        begin
            t = {acc, b[i]};
            if (t >= {1'b0, d})
            begin
                t = t - {1'b0, d};
            end
            acc = t[DW-1:0];
        end
        return acc;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NSTEP);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg <= PW'(operand);
            d_reg  <= divisor;
            r_reg  <= '0;
        end
        else if (busy_reg)
        begin
            r_reg  <= rem_byte(r_reg, sh_reg[PW-1 -: 8], d_reg);
            sh_reg <= sh_reg << 8;
        end
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

/* hw/rtl/lht_dp.sv */
// Datapath: key and fill stores, hash unit, table state and output register.
// Depends on lht_pkg, lht_ram and lht_mod.
module lht_dp
    import lht_pkg::*;
#(
    parameter int MAX_BUCKETS      = MAX_BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = SLOTS_PER_BUCKET_DEF,
    parameter int START_BUCKETS    = START_BUCKETS_DEF,
    parameter int KEY_BITS         = KEY_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lht_cmd_t            cmd,
    output lht_stat_t           st,
    input  logic                s_cmd,
    input  logic [KEY_BITS-1:0] s_key,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [ODATA_W-1:0]  m_tdata
);

    localparam int BW = $clog2(MAX_BUCKETS);
    localparam int AW = $clog2(MAX_BUCKETS * SLOTS_PER_BUCKET);
    localparam int FW = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int UW = $clog2(MAX_BUCKETS + 1);
    localparam int DW = $clog2(MAX_BUCKETS) + 2;
    localparam int LW = $clog2($clog2(MAX_BUCKETS) + 2);

    logic [KEY_BITS-1:0] key_reg;
    logic                search_reg;
    logic [BW-1:0]       home_reg;
    logic [FW-1:0]       fill_reg;
    logic [FW-1:0]       idx_reg;
    logic [FW-1:0]       cnt_old_reg;
    logic [FW-1:0]       cnt_new_reg;
    logic                found_reg;
    logic                stored_reg;
    logic                cansplit_reg;
    logic [LW-1:0]       level_reg;
    logic [BW-1:0]       sp_reg;
    logic [UW-1:0]       biu_reg;
    logic [START_BUCKETS-1:0] fv_reg;
    logic                out_valid_reg;
    logic [ODATA_W-1:0]  out_data_reg;

    logic [DW-1:0]       div0;
    logic [DW-1:0]       div1;
    logic [DW-1:0]       hres;
    logic                hdone;
    logic [BW-1:0]       new_b;
    logic                dest_old;
    logic [DW-1:0]       sp_inc;

    logic                key_we;
    logic [AW-1:0]       key_waddr;
    logic [KEY_BITS-1:0] key_wdata;
    logic                key_re;
    logic [AW-1:0]       key_raddr;
    logic [KEY_BITS-1:0] key_rdata;

    logic                fill_we;
    logic [BW-1:0]       fill_waddr;
    logic [FW-1:0]       fill_wdata;
    logic [BW-1:0]       fill_raddr;
    logic [FW-1:0]       fill_rdata;
    logic                fill_lo;
    logic                fill_ok;
    logic [STAT_W-1:0]   status;

    function automatic logic [AW-1:0] slot_addr(input logic [BW-1:0] b,
                                                input logic [FW-1:0] s);
        return AW'(int'(b) * SLOTS_PER_BUCKET + int'(s));
    endfunction

    assign div0   = DW'(START_BUCKETS) << level_reg;
    assign div1   = DW'(START_BUCKETS) << (level_reg + 1'b1);
    assign new_b  = biu_reg[BW-1:0];
    assign sp_inc = DW'(sp_reg) + 1'b1;
    assign dest_old = (hres == DW'(sp_reg));

    lht_mod #(
        .KW (KEY_BITS),
        .DW (DW)
    ) u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.hash_start),
        .operand (cmd.hash_src_mem ? key_rdata : key_reg),
        .divisor (cmd.hash_sel1 ? div1 : div0),
        .done    (hdone),
        .result  (hres)
    );

    // key store ports
    always_comb
    begin
        key_we    = 1'b0;
        key_waddr = slot_addr(home_reg, fill_reg);
        key_wdata = key_reg;
        if (cmd.ins_write)
        begin
            key_we = (fill_reg < FW'(SLOTS_PER_BUCKET));
        end
        else if (cmd.split_write)
        begin
            key_we    = 1'b1;
            key_wdata = key_rdata;
            key_waddr = dest_old ? slot_addr(sp_reg, cnt_old_reg)
                                 : slot_addr(new_b, cnt_new_reg);
        end
        key_re    = cmd.key_rd_scan | cmd.key_rd_split;
        key_raddr = cmd.key_rd_scan ? slot_addr(home_reg, idx_reg)
                                    : slot_addr(sp_reg, idx_reg);
    end

    lht_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (MAX_BUCKETS * SLOTS_PER_BUCKET)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .re    (key_re),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    // fill store ports
    always_comb
    begin
        fill_we    = 1'b0;
        fill_waddr = home_reg;
        fill_wdata = fill_reg + 1'b1;
        if (cmd.ins_write)
        begin
            fill_we = (fill_reg < FW'(SLOTS_PER_BUCKET));
        end
        else if (cmd.fill_wr_old)
        begin
            fill_we    = 1'b1;
            fill_waddr = sp_reg;
            fill_wdata = cnt_old_reg;
        end
        else if (cmd.fill_wr_new)
        begin
            fill_we    = 1'b1;
            fill_waddr = new_b;
            fill_wdata = cnt_new_reg;
        end
        fill_raddr = cmd.fill_sel_old ? sp_reg : home_reg;
    end

    lht_ram #(
        .WIDTH (FW),
        .DEPTH (MAX_BUCKETS)
    ) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wdata),
        .re    (cmd.fill_rd),
        .raddr (fill_raddr),
        .rdata (fill_rdata)
    );

    // starting buckets read as empty until first written; later ones are
    // zeroed by the split that creates them
    always_comb
    begin
        fill_lo = 1'b0;
        fill_ok = 1'b0;
        for (int k = 0; k < START_BUCKETS; k++)
        begin
            if (fill_raddr == BW'(k))
            begin
                fill_lo = 1'b1;
                fill_ok = fv_reg[k];
            end
        end
    end

    always_comb
    begin
        if (!stored_reg && !search_reg)
        begin
            status = STAT_FULL;
        end
        else if (!cansplit_reg && !search_reg)
        begin
            status = STAT_LIMIT;
        end
        else
        begin
            status = STAT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            sp_reg        <= '0;
            biu_reg       <= UW'(START_BUCKETS);
            fv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fill_we)
            begin
                for (int k = 0; k < START_BUCKETS; k++)
                begin
                    if (fill_waddr == BW'(k))
                    begin
                        fv_reg[k] <= 1'b1;
                    end
                end
            end
            if (cmd.split_finish)
            begin
                biu_reg <= biu_reg + 1'b1;
                if (sp_inc == div0)
                begin
                    sp_reg    <= '0;
                    level_reg <= level_reg + 1'b1;
                end
                else
                begin
                    sp_reg <= sp_reg + 1'b1;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            key_reg    <= s_key;
            search_reg <= (s_cmd == CMD_SEARCH);
            found_reg  <= 1'b0;
            stored_reg <= 1'b1;
            cansplit_reg <= 1'b1;
        end
        if (cmd.set_home)
        begin
            home_reg <= hres[BW-1:0];
        end
        if (cmd.fill_cap)
        begin
            fill_reg <= (fill_lo && !fill_ok) ? '0 : fill_rdata;
            idx_reg  <= '0;
            cnt_old_reg <= '0;
            cnt_new_reg <= '0;
        end
        if (cmd.scan_next)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.set_found)
        begin
            found_reg <= 1'b1;
        end
        if (cmd.ins_write)
        begin
            stored_reg   <= (fill_reg < FW'(SLOTS_PER_BUCKET));
            cansplit_reg <= st.can_split;
        end
        if (cmd.split_write)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (dest_old)
            begin
                cnt_old_reg <= cnt_old_reg + 1'b1;
            end
            else
            begin
                cnt_new_reg <= cnt_new_reg + 1'b1;
            end
        end
        if (cmd.out_load)
        begin
            out_data_reg <= ODATA_W'({home_reg[HOME_W-1:0], status, found_reg});
        end
    end

    assign st.hash_done = hdone;
    assign st.below_sp  = (hres < DW'(sp_reg));
    assign st.is_search = search_reg;
    assign st.can_split = (biu_reg < UW'(MAX_BUCKETS));
    assign st.idx_end   = (idx_reg == fill_reg);
    assign st.match     = (key_rdata == key_reg);
    assign st.out_busy  = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* hw/rtl/lht_ctrl.sv */
// Controller state machine: sequences hashing, scan, insert and split.
// Depends on lht_pkg.
module lht_ctrl
    import lht_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  lht_stat_t st,
    output lht_cmd_t  cmd
);

    typedef enum logic [16:0] {
        ST_IDLE  = 17'b00000000000000001,
        ST_H0S   = 17'b00000000000000010,
        ST_H0W   = 17'b00000000000000100,
        ST_H1S   = 17'b00000000000001000,
        ST_H1W   = 17'b00000000000010000,
        ST_FRD   = 17'b00000000000100000,
        ST_FCAP  = 17'b00000000001000000,
        ST_SRD   = 17'b00000000010000000,
        ST_SCMP  = 17'b00000000100000000,
        ST_INS   = 17'b00000001000000000,
        ST_PFRD  = 17'b00000010000000000,
        ST_PFCAP = 17'b00000100000000000,
        ST_PRD   = 17'b00001000000000000,
        ST_PHS   = 17'b00010000000000000,
        ST_PHW   = 17'b00100000000000000,
        ST_PWO   = 17'b01000000000000000,
        ST_PWN   = 17'b10000000000000000
    } lht_state_t;

    lht_state_t state_reg;
    lht_state_t state_next;
    logic       out_pend_reg;
    logic       out_pend_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            out_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            out_pend_reg <= out_pend_next;
        end
    end

    // a finished result waits in IDLE until the output register frees up
    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        out_pend_next = out_pend_reg;
        s_tready      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (out_pend_reg)
                begin
                    if (!st.out_busy)
                    begin
                        cmd.out_load  = 1'b1;
                        out_pend_next = 1'b0;
                    end
                end
                else
                begin
                    s_tready = 1'b1;
                    if (s_tvalid)
                    begin
                        cmd.load_req = 1'b1;
                        state_next   = ST_H0S;
                    end
                end
            end
            ST_H0S:
            begin
                cmd.hash_start = 1'b1;
                state_next     = ST_H0W;
            end
            ST_H0W:
            begin
                if (st.hash_done)
                begin
                    cmd.set_home = 1'b1;
                    state_next   = st.below_sp ? ST_H1S : ST_FRD;
                end
            end
            ST_H1S:
            begin
                cmd.hash_start = 1'b1;
                cmd.hash_sel1  = 1'b1;
                state_next     = ST_H1W;
            end
            ST_H1W:
            begin
                if (st.hash_done)
                begin
                    cmd.set_home = 1'b1;
                    state_next   = ST_FRD;
                end
            end
            ST_FRD:
            begin
                cmd.fill_rd = 1'b1;
                state_next  = ST_FCAP;
            end
            ST_FCAP:
            begin
                cmd.fill_cap = 1'b1;
                state_next   = st.is_search ? ST_SRD : ST_INS;
            end
            ST_SRD:
            begin
                if (st.idx_end)
                begin
                    out_pend_next = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.key_rd_scan = 1'b1;
                    state_next      = ST_SCMP;
                end
            end
            ST_SCMP:
            begin
                if (st.match)
                begin
                    cmd.set_found = 1'b1;
                    out_pend_next = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = ST_SRD;
                end
            end
            ST_INS:
            begin
                cmd.ins_write = 1'b1;
                if (st.can_split)
                begin
                    state_next = ST_PFRD;
                end
                else
                begin
                    out_pend_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_PFRD:
            begin
                cmd.fill_rd      = 1'b1;
                cmd.fill_sel_old = 1'b1;
                state_next       = ST_PFCAP;
            end
            ST_PFCAP:
            begin
                cmd.fill_cap     = 1'b1;
                cmd.fill_sel_old = 1'b1;
                state_next       = ST_PRD;
            end
            ST_PRD:
            begin
                if (st.idx_end)
                begin
                    state_next = ST_PWO;
                end
                else
                begin
                    cmd.key_rd_split = 1'b1;
                    state_next       = ST_PHS;
                end
            end
            ST_PHS:
            begin
                cmd.hash_start   = 1'b1;
                cmd.hash_sel1    = 1'b1;
                cmd.hash_src_mem = 1'b1;
                state_next       = ST_PHW;
            end
            ST_PHW:
            begin
                if (st.hash_done)
                begin
                    cmd.split_write = 1'b1;
                    state_next      = ST_PRD;
                end
            end
            ST_PWO:
            begin
                cmd.fill_wr_old = 1'b1;
                state_next      = ST_PWN;
            end
            ST_PWN:
            begin
                cmd.fill_wr_new  = 1'b1;
                cmd.split_finish = 1'b1;
                out_pend_next    = 1'b1;
                state_next       = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/linear_hash_table.sv */
// Top level of the linear hash table: controller plus datapath.
// Depends on lht_pkg, lht_ctrl and lht_dp.

// One request at a time. The home bucket comes from a serial remainder unit that
// runs once or twice per request. A search then scans its bucket, reading and
// comparing each stored key in turn; an insert writes the key if its bucket has
// room and, while fewer than MAX_BUCKETS buckets are in use, splits the bucket at
// the split pointer, rehashing each of its keys through the same remainder unit
// and then writing both fill counts. A finished result sits in the output
// register while the next request is accepted; no clearing pass is needed after
// reset.
module linear_hash_table
    import lht_pkg::*;
#(
    parameter int MAX_BUCKETS      = MAX_BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = SLOTS_PER_BUCKET_DEF,
    parameter int START_BUCKETS    = START_BUCKETS_DEF,
    parameter int KEY_BITS         = KEY_BITS_DEF,
    localparam int TDATA_W         = ((KEY_BITS + 7) / 8) * 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // key
    input  logic               s_tuser,   // cmd
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [ODATA_W-1:0] m_tdata    // found, status[1:0], home_bucket[5:0]
);

    lht_cmd_t  cmd;
    lht_stat_t st;

    lht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    lht_dp #(
        .MAX_BUCKETS      (MAX_BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
        .START_BUCKETS    (START_BUCKETS),
        .KEY_BITS         (KEY_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .st       (st),
        .s_cmd    (s_tuser),
        .s_key    (s_tdata[KEY_BITS-1:0]),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

/* hw/rtl/lht_checker.sv */
// Port-level assertions for linear_hash_table, bound to the top level.
// Depends on lht_pkg.
module lht_checker
    import lht_pkg::*;
#(
    parameter int TDATA_W = 32
) (
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic [TDATA_W-1:0] s_tdata,
    input logic               s_tuser,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [ODATA_W-1:0] m_tdata
);

    // a stalled result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // one request at a time: busy right after a transfer in
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transfer");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:1] == STAT_OK || m_tdata[2:1] == STAT_FULL ||
                      m_tdata[2:1] == STAT_LIMIT))
        else $error("undefined status code");

    // found only comes from a search, whose status is always ok
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[2:1] == STAT_OK)
        else $error("found with non-ok status");

endmodule

bind linear_hash_table lht_checker #(.TDATA_W(TDATA_W)) u_lht_checker (.*);

/* test/tb_linear_hash_table.sv */
// Self-checking testbench for linear_hash_table: predicts bucket placement,
// splits, drops and searches per request. Depends on lht_pkg and the RTL.
`timescale 1ns / 100ps

module tb_linear_hash_table;
    import lht_pkg::*;

    localparam int NB = MAX_BUCKETS_DEF;
    localparam int NS = SLOTS_PER_BUCKET_DEF;
    localparam int SB = START_BUCKETS_DEF;
    localparam int KB = KEY_BITS_DEF;
    localparam int TW = ((KB + 7) / 8) * 8;
    localparam int N_RANDOM = 1430;
    localparam int STALL_LIMIT = 20000;

    // found in the lowest bit, home bucket on top
    typedef struct packed {
        logic [HOME_W-1:0] home;
        logic [STAT_W-1:0] status;
        logic              found;
    } lookup_t;

    class hash_scoreboard;
        logic [KB-1:0] keys[NB][NS];
        int            fill[NB];
        int            level;
        int            sptr;
        int            used;
        lookup_t       pending[$];
        int            errors;
        int            n_full;
        int            n_limit;
        int            n_hits;

        function new();
            foreach (fill[i]) fill[i] = 0;
            level = 0;
            sptr = 0;
            used = SB;
            errors = 0;
            n_full = 0;
            n_limit = 0;
            n_hits = 0;
        endfunction

        function int home_of(logic [KB-1:0] k);
            longint unsigned idx;
            idx = k % (longint'(SB) << level);
            if (idx < sptr) idx = k % (longint'(SB) << (level + 1));
            return int'(idx);
        endfunction

        function bit append(int b, logic [KB-1:0] k);
            if (b >= NB || fill[b] >= NS) return 0;
            keys[b][fill[b]] = k;
            fill[b]++;
            return 1;
        endfunction

        function void split();
            logic [KB-1:0] held[NS];
            int n;
            int old_b;
            old_b = sptr;
            if (old_b >= NB || used >= NB) return;
            n = fill[old_b];
            for (int i = 0; i < n; i++) held[i] = keys[old_b][i];
            fill[old_b] = 0;
            fill[used] = 0;
            used++;
            for (int i = 0; i < n; i++)
                void'(append(int'(held[i] % (longint'(SB) << (level + 1))), held[i]));
            sptr++;
            if (sptr == (SB << level))
            begin
                sptr = 0;
                level++;
            end
        endfunction

        function void note_request(logic cmd, logic [KB-1:0] k);
            lookup_t r;
            int h;
            bit stored;
            bit can_split;
            h = home_of(k);
            r = '0;
            r.home = h[HOME_W-1:0];
            if (cmd == CMD_INSERT)
            begin
                stored = append(h, k);
                can_split = used < NB;
                if (can_split) split();
                if (!stored)
                begin
                    r.status = STAT_FULL;
                    n_full++;
                end
                else if (!can_split)
                begin
                    r.status = STAT_LIMIT;
                    n_limit++;
                end
            end
            else if (h < NB)
            begin
                for (int i = 0; i < fill[h]; i++)
                    if (keys[h][i] == k) r.found = 1'b1;
                if (r.found) n_hits++;
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [ODATA_W-1:0] d);
            lookup_t e;
            lookup_t a;
            a = d[$bits(lookup_t)-1:0];
            if (pending.size() == 0)
            begin
                $error("result with nothing expected: %h", d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.found !== e.found)
            begin
                $error("found: expected %0d, got %0d", e.found, a.found);
                errors++;
            end
            if (a.status !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, a.status);
                errors++;
            end
            if (a.home !== e.home)
            begin
                $error("home_bucket: expected %0d, got %0d", e.home, a.home);
                errors++;
            end
            if (d[ODATA_W-1:$bits(lookup_t)] !== '0)
            begin
                $error("tdata pad: expected 0, got %h", d[ODATA_W-1:$bits(lookup_t)]);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [TW-1:0]      s_tdata;   // key
    logic               s_tuser;   // cmd
    logic               m_tvalid;
    logic               m_tready;
    logic [ODATA_W-1:0] m_tdata;   // found, status[1:0], home_bucket[5:0]

    hash_scoreboard sb;
    int  src_idle_pct;
    int  snk_idle_pct;
    int  idle_cnt;
    logic [KB-1:0] recent[$];

    linear_hash_table dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // handshake lines are stable at the falling edge; a transfer there
    // completes at the next rising edge
    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // result side: random stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= STALL_LIMIT)
        begin
            $display("tb_linear_hash_table NOT OK");
            $finish;
        end
    end

    task automatic send(logic cmd, logic [KB-1:0] k);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= TW'(k);
        @(negedge clk);
        while (!s_tready) @(negedge clk);
        @(posedge clk);
        sb.note_request(cmd, k);
        if (cmd == CMD_INSERT)
        begin
            recent.push_back(k);
            if (recent.size() > 64) void'(recent.pop_front());
        end
    endtask

    function automatic logic [KB-1:0] rand_key();
        logic [KB-1:0] k;
        case ($urandom_range(3))
            0: k = KB'($urandom_range(255));
            1: k = KB'({$urandom, $urandom});
            default: k = KB'($urandom_range(4095)) * 64; // crowds low buckets
        endcase
        return k;
    endfunction

    initial
    begin
        logic cmd;
        logic [KB-1:0] k;
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_INSERT;
        m_tready = 1'b0;
        idle_cnt = 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme keys, search hit and miss, duplicate, full bucket
        send(CMD_SEARCH, '0);
        send(CMD_INSERT, '0);
        send(CMD_INSERT, {KB{1'b1}});
        send(CMD_INSERT, {KB{1'b1}});
        send(CMD_SEARCH, {KB{1'b1}});
        send(CMD_SEARCH, '0);
        send(CMD_SEARCH, KB'(12345));
        send(CMD_INSERT, KB'(32'h2AAA_AAAA));
        send(CMD_INSERT, KB'(32'h5555_5555));
        for (int i = 0; i < 14; i++) send(CMD_INSERT, KB'(i) << 12);
        send(CMD_SEARCH, KB'(32'h5555_5555));

        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 46 : 0;
            snk_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 35 : 0;
            for (int i = 0; i < N_RANDOM / 3; i++)
            begin
                cmd = 1'($urandom_range(1));
                if (cmd == CMD_SEARCH && recent.size() > 0 && $urandom_range(1))
                    k = recent[$urandom_range(recent.size() - 1)];
                else
                    k = rand_key();
                send(cmd, k);
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending.size() > 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("covered: %0d full drops, %0d limit-reached inserts, %0d search hits",
                 sb.n_full, sb.n_limit, sb.n_hits);
        $display("final level %0d, %0d buckets in use", sb.level, sb.used);
        if (sb.errors == 0)
            $display("tb_linear_hash_table OK");
        else
            $display("tb_linear_hash_table NOT OK");
        $finish;
    end

endmodule
